// ----- sv/mlem_pkg.sv -----
// Shared types and constants for the MLEM reconstruction block.
`default_nettype none
package mlem_pkg;
    typedef enum logic [1:0] {
        ACT_WEIGHT = 2'd0,
        ACT_SENS   = 2'd1,
        ACT_START  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    localparam logic REG_ITER = 1'b0;
    localparam logic REG_PEAK = 1'b1;

    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;
    localparam logic [6:0]  MAX_PEAKS = 7'd64;
    localparam logic [15:0] ITER_RST  = 16'd2000;
    localparam logic [6:0]  PEAK_RST  = 7'd25;
endpackage
`default_nettype wire

// ----- sv/mlem_div.sv -----
// Bit-serial 64/32 unsigned divider with 32-bit saturation and zero-divisor rule.
`default_nettype none
module mlem_div
    import mlem_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [31:0] den,
    output logic             done,
    output logic [31:0]      quo
);
    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_DONE = 3'b100
    } dstate_t;

    dstate_t     state_reg, state_next;
    logic [31:0] rem_reg;
    logic [31:0] q_reg;
    logic [31:0] den_reg;
    logic [4:0]  cnt_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, q_reg[31]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE: if (start) state_next = (den == 32'd0 || num[63:32] >= den) ? D_DONE : D_RUN;
            D_RUN:  if (cnt_reg == 5'd31) state_next = D_DONE;
            D_DONE: state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == D_RUN) cnt_reg <= cnt_reg + 5'd1;
            else                    cnt_reg <= 5'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            den_reg <= den;
            rem_reg <= num[63:32];
            if (den == 32'd0)             q_reg <= 32'd0;
            else if (num[63:32] >= den)   q_reg <= SAT32;
            else                          q_reg <= num[31:0];
        end
        else if (state_reg == D_RUN)
        begin
            rem_reg <= fits ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            q_reg   <= {q_reg[30:0], fits};
        end
    end

    assign done = (state_reg == D_DONE);
    assign quo  = q_reg;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == D_IDLE) else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == D_RUN && cnt_reg == 5'd31 |=> done) else $error("run length wrong");
`endif
endmodule
`default_nettype wire

// ----- sv/mlem_image_reconstruction.sv -----
// MLEM reconstruction top level: loaders, sequencer, stores and peak report.
// Load beats (weights row by row, then sensitivities) are taken while idle. A start
// beat runs iteration_count MLEM updates on a GRID_SIDE x GRID_SIDE image, then
// reports the peak_count brightest pixels (1 to 64), one beat each, last_peak on the final.
// in_ready is low from start until the last peak beat is loaded. One update runs
// forward projection, back projection (shortened for a weight whose ratio saturates)
// and the pixel update (shortened when the quotient saturates or the sensitivity is
// zero); the bit-serial divider sets the pace. Each peak takes a scan of the image
// store. After a run both load pointers return to zero.
`default_nettype none
module mlem_image_reconstruction
    import mlem_pkg::*;
#(
    parameter int MAX_EVENTS = 1024,
    parameter int GRID_SIDE  = 10
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       peak_column,
    output logic [3:0]       peak_row,
    output logic [31:0]      pixel_value,
    output logic             last_peak,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int PIXELS = GRID_SIDE * GRID_SIDE;
    localparam int WDEPTH = MAX_EVENTS * PIXELS;
    localparam int PW     = $clog2(PIXELS);
    localparam int CW     = $clog2(GRID_SIDE);
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int EW     = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int EVW    = $clog2(MAX_EVENTS + 1);
    localparam int SPW    = $clog2(PIXELS + 1);

    // one-hot sequencer
    typedef enum logic [20:0] {
        S_IDLE   = 21'd1 << 0,
        S_INIT   = 21'd1 << 1,
        S_ITER   = 21'd1 << 2,
        S_F_RD   = 21'd1 << 3,
        S_F_MUL  = 21'd1 << 4,
        S_F_ACC  = 21'd1 << 5,
        S_F_WR   = 21'd1 << 6,
        S_CLR    = 21'd1 << 7,
        S_B_ROW  = 21'd1 << 8,
        S_B_CHK  = 21'd1 << 9,
        S_B_RD   = 21'd1 << 10,
        S_B_DIV  = 21'd1 << 11,
        S_B_WAIT = 21'd1 << 12,
        S_U_RD   = 21'd1 << 13,
        S_U_MUL  = 21'd1 << 14,
        S_U_DIV  = 21'd1 << 15,
        S_U_WAIT = 21'd1 << 16,
        S_PK_INI = 21'd1 << 17,
        S_PK_RD  = 21'd1 << 18,
        S_PK_CMP = 21'd1 << 19,
        S_PK_EMT = 21'd1 << 20
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0] iter_cfg_reg;
    logic [6:0]  peak_cfg_reg;

    // loaders
    logic [WAW-1:0] wptr_reg;
    logic [PW-1:0]  wcol_reg;
    logic [EVW-1:0] ev_reg;
    logic [SPW-1:0] sptr_reg;

    // loop counters
    logic [PW-1:0]  p_reg;
    logic [EW-1:0]  e_reg;
    logic [WAW-1:0] waddr_reg;
    logic [15:0]    it_reg;
    logic [6:0]     k_reg;
    logic [CW-1:0]  col_reg, row_reg;

    // datapath
    logic [63:0] mul_reg;
    logic [63:0] acc_reg;
    logic [31:0] f_reg;
    logic [31:0] best_reg;
    logic [PW-1:0] bidx_reg;
    logic [CW-1:0] bcol_reg, brow_reg;

    // stores
    logic [31:0] w_mem    [WDEPTH];
    logic [31:0] sens_mem [PIXELS];
    logic [31:0] img_mem  [PIXELS];
    logic [31:0] back_mem [PIXELS];
    logic [31:0] proj_mem [MAX_EVENTS];
    logic [31:0] w_rd, sens_rd, img_rd, back_rd, proj_rd;

    // output register
    logic        out_valid_reg;
    logic [3:0]  ocol_reg, orow_reg;
    logic [31:0] oval_reg;
    logic        olast_reg;

    logic        in_fire, start_fire;
    logic        p_last, e_last, it_last, k_last, ev_zero, out_free;
    logic [6:0]  n_peaks;
    logic [64:0] acc_sum;
    logic [32:0] back_sum;
    logic [31:0] back_wdata;
    logic [31:0] proj_val;
    logic        div_start, div_done;
    logic [63:0] div_num;
    logic [31:0] div_den, div_quo;
    logic        img_we;
    logic [31:0] img_wdata;
    logic [PW-1:0] img_waddr;
    logic [CW:0] col_p1, row_p1;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign start_fire = in_fire && action_t'(action) == ACT_START;
    assign cfg_ready  = 1'b1;

    assign p_last  = (p_reg == PW'(PIXELS - 1));
    assign e_last  = (EVW'(e_reg) + EVW'(1) == ev_reg);
    assign it_last = ({1'b0, it_reg} + 17'd1 == {1'b0, iter_cfg_reg});
    assign ev_zero = (ev_reg == '0);
    assign n_peaks = (peak_cfg_reg == 7'd0) ? 7'd1 :
                     (peak_cfg_reg > MAX_PEAKS) ? MAX_PEAKS : peak_cfg_reg;
    assign k_last  = (k_reg + 7'd1 == n_peaks);
    assign out_free = !out_valid_reg || out_ready;

    // saturating adders and clip of the projection
    assign acc_sum    = {1'b0, acc_reg} + {1'b0, mul_reg};
    assign back_sum   = {1'b0, back_rd} + {1'b0, div_quo};
    assign back_wdata = back_sum[32] ? SAT32 : back_sum[31:0];
    assign proj_val   = (acc_reg[63:48] != 16'd0) ? SAT32 : acc_reg[47:16];

    // shared divider: weight ratio during back projection, update divide after
    assign div_start = (state_reg == S_B_DIV) || (state_reg == S_U_DIV && sens_rd != 32'd0);
    assign div_num   = (state_reg == S_B_DIV) ? {16'd0, w_rd, 16'd0} : mul_reg;
    assign div_den   = (state_reg == S_B_DIV) ? f_reg : sens_rd;

    mlem_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // image store write port
    always_comb
    begin
        img_we    = 1'b0;
        img_waddr = p_reg;
        img_wdata = 32'd0;
        unique case (state_reg)
            S_INIT:
            begin
                img_we    = 1'b1;
                img_wdata = ONE_Q16;
            end
            S_U_DIV:  img_we = (sens_rd == 32'd0);
            S_U_WAIT:
            begin
                img_we    = div_done;
                img_wdata = div_quo;
            end
            S_PK_EMT:
            begin
                img_we    = out_free;
                img_waddr = bidx_reg;
            end
            default: img_we = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (start_fire) state_next = S_INIT;
            S_INIT:   if (p_last) state_next = (iter_cfg_reg == 16'd0) ? S_PK_INI : S_ITER;
            S_ITER:   state_next = ev_zero ? S_CLR : S_F_RD;
            S_F_RD:   state_next = S_F_MUL;
            S_F_MUL:  state_next = S_F_ACC;
            S_F_ACC:  state_next = p_last ? S_F_WR : S_F_RD;
            S_F_WR:   state_next = e_last ? S_CLR : S_F_RD;
            S_CLR:    if (p_last) state_next = ev_zero ? S_U_RD : S_B_ROW;
            S_B_ROW:  state_next = S_B_CHK;
            S_B_CHK:
            begin
                if (proj_rd != 32'd0) state_next = S_B_RD;
                else                  state_next = e_last ? S_U_RD : S_B_ROW;
            end
            S_B_RD:   state_next = S_B_DIV;
            S_B_DIV:  state_next = S_B_WAIT;
            S_B_WAIT:
            begin
                if (div_done)
                begin
                    if (!p_last)     state_next = S_B_RD;
                    else if (e_last) state_next = S_U_RD;
                    else             state_next = S_B_ROW;
                end
            end
            S_U_RD:   state_next = S_U_MUL;
            S_U_MUL:  state_next = S_U_DIV;
            S_U_DIV:
            begin
                if (sens_rd != 32'd0) state_next = S_U_WAIT;
                else if (p_last)      state_next = it_last ? S_PK_INI : S_ITER;
                else                  state_next = S_U_RD;
            end
            S_U_WAIT:
            begin
                if (div_done)
                begin
                    if (p_last) state_next = it_last ? S_PK_INI : S_ITER;
                    else        state_next = S_U_RD;
                end
            end
            S_PK_INI: state_next = S_PK_RD;
            S_PK_RD:  state_next = S_PK_CMP;
            S_PK_CMP: state_next = p_last ? S_PK_EMT : S_PK_RD;
            S_PK_EMT: if (out_free) state_next = k_last ? S_IDLE : S_PK_INI;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_cfg_reg  <= ITER_RST;
            peak_cfg_reg  <= PEAK_RST;
            wptr_reg      <= '0;
            wcol_reg      <= '0;
            ev_reg        <= '0;
            sptr_reg      <= '0;
            p_reg         <= '0;
            e_reg         <= '0;
            waddr_reg     <= '0;
            it_reg        <= '0;
            k_reg         <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ITER: iter_cfg_reg <= cfg_data;
                    REG_PEAK: peak_cfg_reg <= cfg_data[6:0];
                    default:  iter_cfg_reg <= iter_cfg_reg;
                endcase
            end

            // output beat: set on emit, cleared once taken
            if (state_reg == S_PK_EMT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            // loaders; rows are counted as they complete
            if (in_fire && action_t'(action) == ACT_WEIGHT && ev_reg < EVW'(MAX_EVENTS))
            begin
                wptr_reg <= wptr_reg + WAW'(1);
                if (wcol_reg == PW'(PIXELS - 1))
                begin
                    wcol_reg <= '0;
                    ev_reg   <= ev_reg + EVW'(1);
                end
                else
                begin
                    wcol_reg <= wcol_reg + PW'(1);
                end
            end
            if (in_fire && action_t'(action) == ACT_SENS && sptr_reg < SPW'(PIXELS))
                sptr_reg <= sptr_reg + SPW'(1);

            unique case (state_reg)
                S_IDLE:
                begin
                    p_reg  <= '0;
                    it_reg <= '0;
                    k_reg  <= '0;
                end
                S_INIT:   p_reg <= p_last ? '0 : p_reg + PW'(1);
                S_ITER:
                begin
                    p_reg     <= '0;
                    e_reg     <= '0;
                    waddr_reg <= '0;
                end
                S_F_ACC:
                begin
                    p_reg     <= p_last ? '0 : p_reg + PW'(1);
                    waddr_reg <= waddr_reg + WAW'(1);
                end
                S_F_WR:   e_reg <= e_last ? '0 : e_reg + EW'(1);
                S_CLR:
                begin
                    p_reg     <= p_last ? '0 : p_reg + PW'(1);
                    e_reg     <= '0;
                    waddr_reg <= '0;
                end
                S_B_CHK:
                begin
                    if (proj_rd == 32'd0)
                    begin
                        waddr_reg <= waddr_reg + WAW'(PIXELS);
                        e_reg     <= e_reg + EW'(1);
                    end
                end
                S_B_WAIT:
                begin
                    if (div_done)
                    begin
                        waddr_reg <= waddr_reg + WAW'(1);
                        p_reg     <= p_last ? '0 : p_reg + PW'(1);
                        if (p_last) e_reg <= e_reg + EW'(1);
                    end
                end
                S_U_DIV:
                begin
                    if (sens_rd == 32'd0)
                    begin
                        p_reg <= p_last ? '0 : p_reg + PW'(1);
                        if (p_last) it_reg <= it_reg + 16'd1;
                    end
                end
                S_U_WAIT:
                begin
                    if (div_done)
                    begin
                        p_reg <= p_last ? '0 : p_reg + PW'(1);
                        if (p_last) it_reg <= it_reg + 16'd1;
                    end
                end
                S_PK_INI:
                begin
                    p_reg   <= '0;
                    col_reg <= '0;
                    row_reg <= '0;
                end
                S_PK_CMP:
                begin
                    p_reg <= p_reg + PW'(1);
                    if (col_reg == CW'(GRID_SIDE - 1))
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + CW'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + CW'(1);
                    end
                end
                S_PK_EMT:
                begin
                    if (out_free)
                    begin
                        k_reg <= k_reg + 7'd1;
                        if (k_last)
                        begin
                            // run done: next run loads a fresh matrix
                            wptr_reg <= '0;
                            wcol_reg <= '0;
                            ev_reg   <= '0;
                            sptr_reg <= '0;
                        end
                    end
                end
                default: p_reg <= p_reg;
            endcase
        end
    end

    assign col_p1 = {1'b0, bcol_reg} + (CW + 1)'(1);
    assign row_p1 = {1'b0, brow_reg} + (CW + 1)'(1);

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        mul_reg <= ((state_reg == S_U_MUL) ? back_rd : w_rd) * img_rd;
        if (state_reg == S_ITER || state_reg == S_F_WR) acc_reg <= 64'd0;
        else if (state_reg == S_F_ACC) acc_reg <= acc_sum[64] ? {64{1'b1}} : acc_sum[63:0];
        if (state_reg == S_B_CHK) f_reg <= proj_rd;
        // first maximum wins: only a strictly larger value replaces it
        if (state_reg == S_PK_CMP && (p_reg == '0 || img_rd > best_reg))
        begin
            best_reg <= img_rd;
            bidx_reg <= p_reg;
            bcol_reg <= col_reg;
            brow_reg <= row_reg;
        end
        if (state_reg == S_PK_EMT && out_free)
        begin
            ocol_reg  <= 4'(col_p1);
            orow_reg  <= 4'(row_p1);
            oval_reg  <= best_reg;
            olast_reg <= k_last;
        end
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (in_fire && action_t'(action) == ACT_WEIGHT && ev_reg < EVW'(MAX_EVENTS))
            w_mem[wptr_reg] <= value;
        w_rd <= w_mem[waddr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && action_t'(action) == ACT_SENS && sptr_reg < SPW'(PIXELS))
            sens_mem[PW'(sptr_reg)] <= value;
        sens_rd <= sens_mem[p_reg];
    end

    always_ff @(posedge clk)
    begin
        if (img_we) img_mem[img_waddr] <= img_wdata;
        img_rd <= img_mem[p_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLR) back_mem[p_reg] <= 32'd0;
        else if (state_reg == S_B_WAIT && div_done) back_mem[p_reg] <= back_wdata;
        back_rd <= back_mem[p_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_F_WR) proj_mem[e_reg] <= proj_val;
        proj_rd <= proj_mem[e_reg];
    end

    assign out_valid   = out_valid_reg;
    assign peak_column = ocol_reg;
    assign peak_row    = orow_reg;
    assign pixel_value = oval_reg;
    assign last_peak   = olast_reg;

`ifndef NO_ASSERTIONS
    a_start_init: assert property (@(posedge clk) disable iff (!rst_n)
        start_fire |=> state_reg == S_INIT) else $error("start beat not taken");
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PK_EMT && out_free |=> out_valid_reg) else $error("peak beat lost");
    a_ev_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ev_reg <= EVW'(MAX_EVENTS)) else $error("event count overrun");
    a_idle_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PK_EMT && out_free && k_last |=> ev_reg == '0 && sptr_reg == '0)
        else $error("load pointers not cleared");
`endif
endmodule
`default_nettype wire
